@@ rtl/bmrc_pkg.sv @@
// shared types, constants and helper functions for the bitmap range count and search block
`timescale 1ns / 1ps
package bmrc_pkg;

  localparam int LEN_W  = 21;   // string length and byte index
  localparam int IDX_W  = 24;   // range indices, bit positions, count
  localparam int ANS_W  = 25;   // signed answer
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;
  localparam int CALC_W = 27;   // signed range arithmetic

  localparam int MAX_STRING_BYTES_DEF = 1048576;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_OPERATION  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SEARCH_BIT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RANGE_MODE = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BIT_UNITS  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_START      = 3'd4;
  localparam logic [CFG_AW-1:0] REG_END        = 3'd5;
  localparam logic [CFG_AW-1:0] REG_LENGTH     = 3'd6;

  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] MODE_ALL    = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic             err;
    logic             empty;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } rng_t;

  function automatic logic [3:0] popcount8(input logic [7:0] x);
    logic [7:0] x1;
    logic [7:0] x2;
    logic [7:0] x3;
    x1 = x - ((x >> 1) & 8'h55);
    x2 = (x1 & 8'h33) + ((x1 >> 2) & 8'h33);
    x3 = (x2 + (x2 >> 4)) & 8'h0F;
    return x3[3:0];
  endfunction

  // offset of the first set bit counted from the msb
  function automatic logic [2:0] first_one8(input logic [7:0] x);
    logic [2:0] idx;
    idx = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) idx = 3'(7 - k);
    end
    return idx;
  endfunction

endpackage

@@ rtl/bmrc_range.sv @@
// resolves the configured range into an inclusive bit range with clamping and error flags
`timescale 1ns / 1ps
module bmrc_range #(
  parameter int MAX_STRING_BYTES = bmrc_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic                      operation,
  input  logic [1:0]                range_mode,
  input  logic                      bit_units,
  input  logic [bmrc_pkg::IDX_W-1:0] range_start,
  input  logic [bmrc_pkg::IDX_W-1:0] range_end,
  input  logic [bmrc_pkg::LEN_W-1:0] string_length,
  output bmrc_pkg::rng_t            rng
);
  import bmrc_pkg::*;

  logic [LEN_W-1:0]         len;
  logic signed [CALC_W-1:0] tot;
  logic signed [CALC_W-1:0] s0;
  logic signed [CALC_W-1:0] e0;
  logic signed [CALC_W-1:0] s1;
  logic signed [CALC_W-1:0] e1;
  logic signed [CALC_W-1:0] s2;
  logic signed [CALC_W-1:0] e2;
  logic [IDX_W-1:0]         all_hi;

  always_comb begin
    if (32'(string_length) > 32'(MAX_STRING_BYTES)) len = LEN_W'(MAX_STRING_BYTES);
    else len = string_length;

    tot = bit_units ? $signed({3'b000, len, 3'b000}) : $signed({6'b000000, len});
    s0  = $signed({{(CALC_W-IDX_W){range_start[IDX_W-1]}}, range_start});
    e0  = (range_mode == MODE_BOTH) ?
          $signed({{(CALC_W-IDX_W){range_end[IDX_W-1]}}, range_end}) : tot - 27'sd1;

    // negative indices count back from the end
    s1 = (s0 < 0) ? s0 + tot : s0;
    e1 = (e0 < 0) ? e0 + tot : e0;
    s2 = (s1 < 0) ? '0 : s1;
    e2 = (e1 < 0) ? '0 : e1;
    if (e2 >= tot) e2 = tot - 27'sd1;

    all_hi = {len, 3'b000} - IDX_W'(1);

    rng.len   = len;
    rng.err   = 1'b0;
    rng.empty = 1'b0;
    rng.lo    = '0;
    rng.hi    = '0;
    case (range_mode)
      MODE_ALL: begin
        rng.empty = (len == '0);
        rng.hi    = all_hi;
      end
      MODE_START, MODE_BOTH: begin
        rng.err   = (operation == OP_COUNT) && (s0 < 0) && (e0 < 0) && (s0 > e0);
        rng.empty = (s2 > e2);
        rng.lo    = bit_units ? s2[IDX_W-1:0] : {s2[LEN_W-1:0], 3'b000};
        rng.hi    = bit_units ? e2[IDX_W-1:0] : {e2[LEN_W-1:0], 3'b111};
      end
      default: begin
        rng.err = 1'b1;
      end
    endcase
  end

endmodule

@@ rtl/bitmap_range_count_and_search.sv @@
// top level: streams bitmap bytes, accumulates a masked bit count and first-match position
// the result of a string is registered from its tlast byte once the result slot is free
// throughput: one byte per cycle; the count and match registers update once per byte
// a held result does not stop bytes of the next string until its last byte arrives
// reset (rst_n low, synchronous) empties both stages, clears the accumulators and
// loads the register defaults: count, search for 1, whole string, byte units, end -1
`timescale 1ns / 1ps
module bitmap_range_count_and_search #(
  parameter int MAX_STRING_BYTES = bmrc_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bmrc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bmrc_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tlast,   // last_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata   // [24:0] answer, [25] status, zero fill
);
  import bmrc_pkg::*;

  logic             cfg_op_r;
  logic             cfg_sbit_r;
  logic [1:0]       cfg_mode_r;
  logic             cfg_bits_r;
  logic [IDX_W-1:0] cfg_start_r;
  logic [IDX_W-1:0] cfg_end_r;
  logic [LEN_W-1:0] cfg_len_r;

  logic             in_valid_r;
  logic [7:0]       in_data_r;
  logic             in_last_r;

  logic [LEN_W-1:0] bi_r, bi_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;

  logic             out_valid_r;
  logic [ANS_W-1:0] out_answer_r, out_answer_nxt;
  logic             out_status_r, out_status_nxt;

  rng_t             rng;
  logic             out_free;
  logic             proc;
  logic [7:0]       lmask, hmask, mask, cand;
  logic [LEN_W-1:0] lo_b, hi_b;
  logic [IDX_W-1:0] gap;

  bmrc_range #(.MAX_STRING_BYTES(MAX_STRING_BYTES)) u_range (
    .operation    (cfg_op_r),
    .range_mode   (cfg_mode_r),
    .bit_units    (cfg_bits_r),
    .range_start  (cfg_start_r),
    .range_end    (cfg_end_r),
    .string_length(cfg_len_r),
    .rng          (rng)
  );

  assign out_free   = !out_valid_r || out_tready;
  // non-last bytes never need the result slot
  assign proc       = in_valid_r && (!in_last_r || out_free);
  assign in_tready  = !in_valid_r || proc;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_status_r, out_answer_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_op_r    <= OP_COUNT;
      cfg_sbit_r  <= 1'b1;
      cfg_mode_r  <= MODE_ALL;
      cfg_bits_r  <= 1'b0;
      cfg_start_r <= '0;
      cfg_end_r   <= '1;
      cfg_len_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OPERATION:  cfg_op_r    <= cfg_wdata[0];
        REG_SEARCH_BIT: cfg_sbit_r  <= cfg_wdata[0];
        REG_RANGE_MODE: cfg_mode_r  <= cfg_wdata[1:0];
        REG_BIT_UNITS:  cfg_bits_r  <= cfg_wdata[0];
        REG_START:      cfg_start_r <= cfg_wdata;
        REG_END:        cfg_end_r   <= cfg_wdata;
        REG_LENGTH:     cfg_len_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lo_b = rng.lo[IDX_W-1:3];
    hi_b = rng.hi[IDX_W-1:3];

    if (bi_r > lo_b)       lmask = 8'hFF;
    else if (bi_r == lo_b) lmask = 8'hFF >> rng.lo[2:0];
    else                   lmask = 8'h00;

    if (bi_r < hi_b)       hmask = 8'hFF;
    else if (bi_r == hi_b) hmask = ~(8'h7F >> rng.hi[2:0]);
    else                   hmask = 8'h00;

    mask = (rng.err || rng.empty) ? 8'h00 : (lmask & hmask);
    cand = (cfg_sbit_r ? in_data_r : ~in_data_r) & mask;

    bi_nxt    = bi_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    if (bi_r < rng.len) begin
      cnt_nxt = cnt_r + IDX_W'(popcount8(in_data_r & mask));
      if (!found_r && (cand != 8'h00)) begin
        found_nxt = 1'b1;
        pos_nxt   = {bi_r, first_one8(cand)};
      end
      bi_nxt = bi_r + LEN_W'(1);
    end

    // first position not yet delivered, pulled up to the range start
    gap = {bi_nxt, 3'b000};
    if (gap < rng.lo) gap = rng.lo;

    out_status_nxt = 1'b0;
    out_answer_nxt = '1;
    if (cfg_op_r == OP_COUNT) begin
      out_answer_nxt = '0;
      if (rng.err) out_status_nxt = 1'b1;
      else if (!rng.empty) out_answer_nxt = {1'b0, cnt_nxt};
    end else begin
      if (rng.err) out_status_nxt = 1'b1;
      else if (rng.empty) out_answer_nxt = '1;
      else if (found_nxt) out_answer_nxt = {1'b0, pos_nxt};
      else if (cfg_sbit_r) out_answer_nxt = '1;
      else if (gap <= rng.hi) out_answer_nxt = {1'b0, gap};
      else if (cfg_mode_r == MODE_BOTH) out_status_nxt = 1'b1;
      else out_answer_nxt = {({1'b0, rng.hi[IDX_W-1:3]} + (LEN_W+1)'(1)), 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bi_r        <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;

      if (proc && in_last_r) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      if (proc) begin
        if (in_last_r) begin
          bi_r        <= '0;
          cnt_r       <= '0;
          found_r     <= 1'b0;
          pos_r       <= '0;
        end else begin
          bi_r    <= bi_nxt;
          cnt_r   <= cnt_nxt;
          found_r <= found_nxt;
          pos_r   <= pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (proc && in_last_r) begin
      out_answer_r <= out_answer_nxt;
      out_status_r <= out_status_nxt;
    end
  end

endmodule

@@ rtl/bmrc_checker.sv @@
// port-level checks for the bitmap range count and search block, bound to the top level
`timescale 1ns / 1ps
module bmrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a result waiting for the sink keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an error result carries only zero or minus one
  a_err_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25] |-> (out_tdata[24:0] == 25'd0) || (out_tdata[24:0] == '1))
    else $error("error result with a real answer");

  // the only negative answer is minus one
  a_neg_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> out_tdata[24:0] == '1)
    else $error("negative answer other than minus one");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:26] == 6'd0)
    else $error("padding bits of result not zero");

endmodule

bind bitmap_range_count_and_search bmrc_checker u_bmrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
